[rtl/ttdc_pkg.sv]
// Shared types and constants for the touch tap/drag classifier.
package ttdc_pkg;

    // Gesture event codes carried on the result item
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_STARTED  = 2'd1;
    localparam logic [1:0] EV_DRAGGING = 2'd2;
    localparam logic [1:0] EV_TAPPED   = 2'd3;

    // Configuration register map (word index = paddr / 4)
    localparam int unsigned ADDR_BITS = 5;
    localparam int unsigned IDX_BITS  = ADDR_BITS - 2;

    localparam logic [IDX_BITS-1:0] REG_AREA_LEFT   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_AREA_TOP    = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_AREA_WIDTH  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_AREA_HEIGHT = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_TAP_SLOP    = 3'd4;

    localparam int unsigned DATA_BITS = 32;

    // Register reset values before truncation to the coordinate width
    localparam int unsigned AREA_WIDTH_RESET  = 1280;
    localparam int unsigned AREA_HEIGHT_RESET = 720;
    localparam int unsigned TAP_SLOP_RESET    = 20;

    // Gesture control flags
    typedef struct packed {
        logic active;
        logic tap_candidate;
    } gesture_flags_t;

endpackage

[rtl/ttdc_step.sv]
// Per-sample classification logic: next gesture state and the result item.
module ttdc_step
    import ttdc_pkg::*;
#(
    parameter int unsigned COORD_BITS = 12
)
(
    input  gesture_flags_t          flags,
    input  logic [COORD_BITS-1:0]   start_x,
    input  logic [COORD_BITS-1:0]   start_y,
    input  logic [COORD_BITS-1:0]   area_left,
    input  logic [COORD_BITS-1:0]   area_top,
    input  logic [COORD_BITS-1:0]   area_width,
    input  logic [COORD_BITS-1:0]   area_height,
    input  logic [COORD_BITS-1:0]   tap_slop,
    input  logic [3:0]              contact_count,
    input  logic [COORD_BITS-1:0]   point_x,
    input  logic [COORD_BITS-1:0]   point_y,
    output gesture_flags_t          flags_next,
    output logic [COORD_BITS-1:0]   start_x_next,
    output logic [COORD_BITS-1:0]   start_y_next,
    output logic [1:0]              gesture_event,
    output logic [COORD_BITS-1:0]   origin_x,
    output logic [COORD_BITS-1:0]   origin_y,
    output logic signed [COORD_BITS:0] offset_x,
    output logic signed [COORD_BITS:0] offset_y
);

    logic [COORD_BITS:0] right_edge;
    logic [COORD_BITS:0] bottom_edge;
    logic                in_area;
    logic                one_contact;
    logic                any_contact;
    logic [COORD_BITS:0] dx;
    logic [COORD_BITS:0] dy;
    logic [COORD_BITS:0] mag_x;
    logic [COORD_BITS:0] mag_y;
    logic                slop_exceeded;
    logic                still_tap;

    // Area bounds, one bit wider so the edges never wrap
    assign right_edge  = {1'b0, area_left} + {1'b0, area_width};
    assign bottom_edge = {1'b0, area_top} + {1'b0, area_height};
    assign in_area     = (point_x >= area_left) && (point_y >= area_top) &&
                         ({1'b0, point_x} <= right_edge) &&
                         ({1'b0, point_y} <= bottom_edge);

    assign one_contact = (contact_count == 4'd1);
    assign any_contact = (contact_count != 4'd0);

    // Signed movement from the start point and its magnitude
    assign dx    = {1'b0, point_x} - {1'b0, start_x};
    assign dy    = {1'b0, point_y} - {1'b0, start_y};
    assign mag_x = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
    assign mag_y = dy[COORD_BITS] ? (~dy + 1'b1) : dy;

    assign slop_exceeded = (mag_x > {1'b0, tap_slop}) || (mag_y > {1'b0, tap_slop});
    assign still_tap     = flags.tap_candidate && !slop_exceeded;

    // Gesture decision
    always_comb
    begin
        flags_next    = flags;
        start_x_next  = start_x;
        start_y_next  = start_y;
        gesture_event = EV_NONE;
        origin_x      = '0;
        origin_y      = '0;
        offset_x      = '0;
        offset_y      = '0;

        if (!flags.active)
        begin
            if (one_contact && in_area)
            begin
                flags_next.active        = 1'b1;
                flags_next.tap_candidate = 1'b1;
                start_x_next             = point_x;
                start_y_next             = point_y;
                gesture_event            = EV_STARTED;
                origin_x                 = point_x;
                origin_y                 = point_y;
            end
        end
        else if (any_contact)
        begin
            flags_next.tap_candidate = still_tap;
            if (!still_tap)
            begin
                gesture_event = EV_DRAGGING;
                origin_x      = start_x;
                origin_y      = start_y;
                offset_x      = dx;
                offset_y      = dy;
            end
        end
        else
        begin
            // release: a gesture that never left the tap slop is a tap
            if (flags.tap_candidate)
            begin
                gesture_event = EV_TAPPED;
                origin_x      = start_x;
                origin_y      = start_y;
            end
            flags_next.active        = 1'b0;
            flags_next.tap_candidate = 1'b0;
        end
    end

endmodule

[rtl/touch_tap_drag_classifier.sv]
// Top level of the touch tap/drag classifier: config registers, state and result register.
//
// Takes one touch sample per item and returns exactly one result item for each,
// classifying the contact as a gesture start, a drag (with signed offset from the
// start point), a tap on release, or no event. The decision is a handful of compares
// and subtracts between the gesture state registers and the result register, so an
// item can be accepted every cycle while in_ready is high, and in_ready stays high
// while the result register is empty or being taken in the same cycle. Results come
// out in the cycle after acceptance. The five area and slop registers sit on the APB
// port at byte addresses 0, 4, 8, 12 and 16 and should be written only while idle.
module touch_tap_drag_classifier
    import ttdc_pkg::*;
#(
    parameter int unsigned COORD_BITS = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_BITS-1:0]      paddr,
    input  logic [DATA_BITS-1:0]      pwdata,
    output logic [DATA_BITS-1:0]      prdata,
    output logic                      pready,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [3:0]                contact_count,
    input  logic [COORD_BITS-1:0]     point_x,
    input  logic [COORD_BITS-1:0]     point_y,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                gesture_event,
    output logic [COORD_BITS-1:0]     origin_x,
    output logic [COORD_BITS-1:0]     origin_y,
    output logic signed [COORD_BITS:0] offset_x,
    output logic signed [COORD_BITS:0] offset_y
);

    localparam logic [COORD_BITS-1:0] WIDTH_RST  = COORD_BITS'(AREA_WIDTH_RESET);
    localparam logic [COORD_BITS-1:0] HEIGHT_RST = COORD_BITS'(AREA_HEIGHT_RESET);
    localparam logic [COORD_BITS-1:0] SLOP_RST   = COORD_BITS'(TAP_SLOP_RESET);

    logic [COORD_BITS-1:0] area_left_reg;
    logic [COORD_BITS-1:0] area_top_reg;
    logic [COORD_BITS-1:0] area_width_reg;
    logic [COORD_BITS-1:0] area_height_reg;
    logic [COORD_BITS-1:0] tap_slop_reg;

    gesture_flags_t        flags_reg;
    gesture_flags_t        flags_next;
    logic [COORD_BITS-1:0] start_x_reg;
    logic [COORD_BITS-1:0] start_x_next;
    logic [COORD_BITS-1:0] start_y_reg;
    logic [COORD_BITS-1:0] start_y_next;

    logic                      out_valid_reg;
    logic [1:0]                event_reg;
    logic [1:0]                event_next;
    logic [COORD_BITS-1:0]     origin_x_reg;
    logic [COORD_BITS-1:0]     origin_x_next;
    logic [COORD_BITS-1:0]     origin_y_reg;
    logic [COORD_BITS-1:0]     origin_y_next;
    logic signed [COORD_BITS:0] offset_x_reg;
    logic signed [COORD_BITS:0] offset_x_next;
    logic signed [COORD_BITS:0] offset_y_reg;
    logic signed [COORD_BITS:0] offset_y_next;

    logic                  cfg_write;
    logic [IDX_BITS-1:0]   cfg_idx;
    logic [COORD_BITS-1:0] cfg_data;
    logic                  in_accept;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[ADDR_BITS-1:2];
    assign cfg_data  = pwdata[COORD_BITS-1:0];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_left_reg   <= '0;
            area_top_reg    <= '0;
            area_width_reg  <= WIDTH_RST;
            area_height_reg <= HEIGHT_RST;
            tap_slop_reg    <= SLOP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_AREA_LEFT:   area_left_reg   <= cfg_data;
                REG_AREA_TOP:    area_top_reg    <= cfg_data;
                REG_AREA_WIDTH:  area_width_reg  <= cfg_data;
                REG_AREA_HEIGHT: area_height_reg <= cfg_data;
                REG_TAP_SLOP:    tap_slop_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        case (cfg_idx)
            REG_AREA_LEFT:   prdata = DATA_BITS'(area_left_reg);
            REG_AREA_TOP:    prdata = DATA_BITS'(area_top_reg);
            REG_AREA_WIDTH:  prdata = DATA_BITS'(area_width_reg);
            REG_AREA_HEIGHT: prdata = DATA_BITS'(area_height_reg);
            REG_TAP_SLOP:    prdata = DATA_BITS'(tap_slop_reg);
            default:         prdata = '0;
        endcase
    end

    // Accept while the result register is free or being emptied
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    ttdc_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .flags         (flags_reg),
        .start_x       (start_x_reg),
        .start_y       (start_y_reg),
        .area_left     (area_left_reg),
        .area_top      (area_top_reg),
        .area_width    (area_width_reg),
        .area_height   (area_height_reg),
        .tap_slop      (tap_slop_reg),
        .contact_count (contact_count),
        .point_x       (point_x),
        .point_y       (point_y),
        .flags_next    (flags_next),
        .start_x_next  (start_x_next),
        .start_y_next  (start_y_next),
        .gesture_event (event_next),
        .origin_x      (origin_x_next),
        .origin_y      (origin_y_next),
        .offset_x      (offset_x_next),
        .offset_y      (offset_y_next)
    );

    // Gesture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg   <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
        end
        else if (in_accept)
        begin
            flags_reg   <= flags_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            event_reg    <= event_next;
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            offset_x_reg <= offset_x_next;
            offset_y_reg <= offset_y_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign gesture_event = event_reg;
    assign origin_x      = origin_x_reg;
    assign origin_y      = origin_y_reg;
    assign offset_x      = offset_x_reg;
    assign offset_y      = offset_y_reg;

endmodule

[rtl/ttdc_checker.sv]
// Port-level checks for the touch tap/drag classifier, bound to the top level.
module ttdc_checker
    import ttdc_pkg::*;
#(
    parameter int unsigned COORD_BITS = 12
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [1:0]                 gesture_event,
    input  logic [COORD_BITS-1:0]      origin_x,
    input  logic [COORD_BITS-1:0]      origin_y,
    input  logic signed [COORD_BITS:0] offset_x,
    input  logic signed [COORD_BITS:0] offset_y
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gesture_event) &&
        $stable(origin_x) && $stable(origin_y) && $stable(offset_x) && $stable(offset_y))
        else $error("result changed while stalled");

    // An empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no pending result");

    // An empty event carries an all-zero payload
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gesture_event == EV_NONE |->
        origin_x == '0 && origin_y == '0 && offset_x == '0 && offset_y == '0)
        else $error("non-zero payload on empty event");

    // Start and tap events report no offset
    a_start_tap_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (gesture_event == EV_STARTED || gesture_event == EV_TAPPED) |->
        offset_x == '0 && offset_y == '0)
        else $error("offset on start or tap event");

    // An accepted item always produces a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item produced no result");

endmodule

bind touch_tap_drag_classifier ttdc_checker #(
    .COORD_BITS (COORD_BITS)
) u_ttdc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .gesture_event (gesture_event),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .offset_x      (offset_x),
    .offset_y      (offset_y)
);

[verif/ttdc_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the touch tap/drag classifier: tracks the registers, predicts and compares.
module ttdc_result_checker
    import ttdc_pkg::*;
#(
    parameter int unsigned CW = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,

    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [3:0]            contact_count,
    input  logic [CW-1:0]         point_x,
    input  logic [CW-1:0]         point_y,

    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [1:0]            gesture_event,
    input  logic [CW-1:0]         origin_x,
    input  logic [CW-1:0]         origin_y,
    input  logic signed [CW:0]    offset_x,
    input  logic signed [CW:0]    offset_y,

    output int unsigned           pending_results,
    output int unsigned           mismatch_count
);

    typedef struct packed {
        logic [1:0]        ev;
        logic [CW-1:0]     ox;
        logic [CW-1:0]     oy;
        logic signed [CW:0] dx;
        logic signed [CW:0] dy;
    } gesture_result_t;

    // Results predicted but not yet seen, oldest first
    gesture_result_t expected_q[$];

    // Local copy of the area and slop registers
    logic [CW-1:0] area_left;
    logic [CW-1:0] area_top;
    logic [CW-1:0] area_width;
    logic [CW-1:0] area_height;
    logic [CW-1:0] tap_slop;

    // Local copy of the gesture state
    gesture_flags_t flags;
    logic [CW-1:0]  start_x;
    logic [CW-1:0]  start_y;

    int unsigned errors;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t ns: MISMATCH %s", $time, msg);
    endtask

    // Classify one touch sample and advance the gesture state
    function automatic gesture_result_t classify_sample(input logic [3:0] cnt,
                                                       input logic [CW-1:0] px,
                                                       input logic [CW-1:0] py);
        gesture_result_t    res;
        logic [CW:0]        right_edge;
        logic [CW:0]        bottom_edge;
        logic signed [CW:0] dx;
        logic signed [CW:0] dy;
        logic [CW:0]        mag_x;
        logic [CW:0]        mag_y;
        res = '0;
        // edges one bit wider so they never wrap
        right_edge  = {1'b0, area_left} + {1'b0, area_width};
        bottom_edge = {1'b0, area_top} + {1'b0, area_height};
        if (!flags.active) begin
            if (cnt == 4'd1 && px >= area_left && py >= area_top &&
                {1'b0, px} <= right_edge && {1'b0, py} <= bottom_edge) begin
                flags.active        = 1'b1;
                flags.tap_candidate = 1'b1;
                start_x             = px;
                start_y             = py;
                res.ev              = EV_STARTED;
                res.ox              = px;
                res.oy              = py;
            end
        end
        else if (cnt != 4'd0) begin
            dx    = $signed({1'b0, px}) - $signed({1'b0, start_x});
            dy    = $signed({1'b0, py}) - $signed({1'b0, start_y});
            mag_x = dx[CW] ? -dx : dx;
            mag_y = dy[CW] ? -dy : dy;
            if (flags.tap_candidate &&
                (mag_x > {1'b0, tap_slop} || mag_y > {1'b0, tap_slop}))
                flags.tap_candidate = 1'b0;
            // the sample that leaves the slop already reports the drag
            if (!flags.tap_candidate) begin
                res.ev = EV_DRAGGING;
                res.ox = start_x;
                res.oy = start_y;
                res.dx = dx;
                res.dy = dy;
            end
        end
        else begin
            // release: a tap only if the contact never left the slop
            if (flags.tap_candidate) begin
                res.ev = EV_TAPPED;
                res.ox = start_x;
                res.oy = start_y;
            end
            flags = '0;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        gesture_result_t want;
        if (!rst_n) begin
            expected_q.delete();
            area_left       = '0;
            area_top        = '0;
            area_width      = CW'(AREA_WIDTH_RESET);
            area_height     = CW'(AREA_HEIGHT_RESET);
            tap_slop        = CW'(TAP_SLOP_RESET);
            flags           = '0;
            start_x         = '0;
            start_y         = '0;
            errors          = 0;
            pending_results <= 0;
            mismatch_count  <= 0;
        end
        else begin
            // compare the result item taken at this edge
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result item with none expected, event %0d",
                                              gesture_event));
                end
                else begin
                    want = expected_q.pop_front();
                    if (gesture_event !== want.ev)
                        report_mismatch($sformatf("gesture_event got %0d, expected %0d",
                                                  gesture_event, want.ev));
                    if (origin_x !== want.ox)
                        report_mismatch($sformatf("origin_x got %0d, expected %0d",
                                                  origin_x, want.ox));
                    if (origin_y !== want.oy)
                        report_mismatch($sformatf("origin_y got %0d, expected %0d",
                                                  origin_y, want.oy));
                    if (offset_x !== want.dx)
                        report_mismatch($sformatf("offset_x got %0d, expected %0d",
                                                  offset_x, want.dx));
                    if (offset_y !== want.dy)
                        report_mismatch($sformatf("offset_y got %0d, expected %0d",
                                                  offset_y, want.dy));
                end
            end

            // predict the result of the sample taken at this edge
            if (in_valid && in_ready)
                expected_q.push_back(classify_sample(contact_count, point_x, point_y));

            // register writes; unused indexes are ignored
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_BITS-1:2])
                    REG_AREA_LEFT:   area_left   = pwdata[CW-1:0];
                    REG_AREA_TOP:    area_top    = pwdata[CW-1:0];
                    REG_AREA_WIDTH:  area_width  = pwdata[CW-1:0];
                    REG_AREA_HEIGHT: area_height = pwdata[CW-1:0];
                    REG_TAP_SLOP:    tap_slop    = pwdata[CW-1:0];
                    default:         ;
                endcase
            end

            pending_results <= expected_q.size();
            mismatch_count  <= errors;
        end
    end

endmodule

[verif/touch_tap_drag_classifier_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the touch tap/drag classifier: stimulus, idling, watchdog and verdict.
module touch_tap_drag_classifier_tb;
    import ttdc_pkg::*;

    localparam int unsigned CW              = 12;
    localparam int          COORD_MAX       = (1 << CW) - 1;
    localparam int unsigned RANDOM_ITEMS    = 1750;
    localparam int unsigned NUM_PHASES      = 7;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES    = 4;
    // index past the end of the register map
    localparam logic [IDX_BITS-1:0] REG_SPARE = 3'd5;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_BITS-1:0]  paddr;
    logic [DATA_BITS-1:0]  pwdata;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic [3:0]            contact_count;
    logic [CW-1:0]         point_x;
    logic [CW-1:0]         point_y;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            gesture_event;
    logic [CW-1:0]         origin_x;
    logic [CW-1:0]         origin_y;
    logic signed [CW:0]    offset_x;
    logic signed [CW:0]    offset_y;

    int unsigned pending_results;
    int unsigned mismatch_count;

    // Stimulus control shared between the sender and receiver
    bit          tx_idling;
    bit          rx_idling;
    bit          hold_off_req;
    int unsigned gesture_items;
    int          cur_left;
    int          cur_top;
    int          cur_width;
    int          cur_height;
    int          cur_slop;

    touch_tap_drag_classifier #(
        .COORD_BITS (CW)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .contact_count (contact_count),
        .point_x       (point_x),
        .point_y       (point_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .gesture_event (gesture_event),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .offset_x      (offset_x),
        .offset_y      (offset_y)
    );

    ttdc_result_checker #(
        .CW (CW)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .contact_count   (contact_count),
        .point_x         (point_x),
        .point_y         (point_y),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .gesture_event   (gesture_event),
        .origin_x        (origin_x),
        .origin_y        (origin_y),
        .offset_x        (offset_x),
        .offset_y        (offset_y),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned next_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    // Coordinate around a start point: inside the slop, on its edge, or anywhere
    function automatic int near_coord(input int centre);
        int step;
        case ($urandom_range(0, 3))
            0:       step = $urandom_range(0, cur_slop);
            1:       step = cur_slop + $urandom_range(0, 1);
            2:       step = $urandom_range(0, COORD_MAX);
            default: step = $urandom_range(0, 3);
        endcase
        if ($urandom_range(0, 1))
            step = -step;
        return clamp_coord(centre + step);
    endfunction

    function automatic int pick_slop();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return COORD_MAX;
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned stall_left;
        out_ready  = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else begin
                out_ready <= 1'b1;
                if (rx_idling && $urandom_range(0, 3) == 0)
                    stall_left = next_gap();
            end
        end
    end

    // Watchdog: ends the run after too long with nothing accepted
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Register write: setup cycle then access cycle; junk in the unused upper bits
    task automatic apb_write(input logic [IDX_BITS-1:0] idx, input int unsigned value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (value & COORD_MAX) | ($urandom() & ~COORD_MAX);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_area(input int l, input int t, input int w, input int h,
                                input int s);
        apb_write(REG_AREA_LEFT, l);
        apb_write(REG_AREA_TOP, t);
        apb_write(REG_AREA_WIDTH, w);
        apb_write(REG_AREA_HEIGHT, h);
        apb_write(REG_TAP_SLOP, s);
        cur_left   = l;
        cur_top    = t;
        cur_width  = w;
        cur_height = h;
        cur_slop   = s;
    endtask

    // Stop sending and wait for every outstanding result item
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Offer one sample item and wait until it is taken
    task automatic send_sample(input int c, input int x, input int y);
        int unsigned gap;
        gap = tx_idling ? next_gap() : 0;
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        contact_count <= 4'(c);
        point_x       <= CW'(x);
        point_y       <= CW'(y);
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // One gesture: touch down, some moves, release
    task automatic run_gesture();
        int x_hi;
        int y_hi;
        int sx;
        int sy;
        int moves;
        x_hi = clamp_coord(cur_left + cur_width);
        y_hi = clamp_coord(cur_top + cur_height);
        if ($urandom_range(0, 9) == 0) begin
            sx = $urandom_range(0, COORD_MAX);
            sy = $urandom_range(0, COORD_MAX);
        end
        else begin
            sx = $urandom_range(x_hi, cur_left);
            sy = $urandom_range(y_hi, cur_top);
        end
        send_sample(($urandom_range(0, 9) == 0) ? $urandom_range(2, 15) : 1, sx, sy);
        moves = $urandom_range(0, 10);
        for (int i = 0; i < moves; i++)
            send_sample(($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 1,
                        near_coord(sx), near_coord(sy));
        send_sample(0, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        gesture_items += moves + 2;
    endtask

    // Main stimulus
    initial
    begin
        int unsigned target;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        contact_count = '0;
        point_x       = '0;
        point_y       = '0;
        tx_idling     = 1'b1;
        rx_idling     = 1'b1;
        hold_off_req  = 1'b0;
        gesture_items = 0;
        cur_left      = 0;
        cur_top       = 0;
        cur_width     = AREA_WIDTH_RESET;
        cur_height    = AREA_HEIGHT_RESET;
        cur_slop      = TAP_SLOP_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset area: ignored samples, inclusive far corner, tap
        send_sample(0, 0, 0);
        send_sample(2, 10, 10);
        send_sample(1, 1281, 5);
        send_sample(1, 1280, 720);
        send_sample(1, 1300, 700);
        send_sample(15, 1260, 740);
        send_sample(0, 0, 0);
        // near corner start, slop exceeded by one, drag then release
        send_sample(1, 0, 0);
        send_sample(1, 21, 0);
        send_sample(3, 0, 0);
        send_sample(1, COORD_MAX, COORD_MAX);
        send_sample(0, COORD_MAX, COORD_MAX);
        send_sample(1, 0, 721);

        // Edges beyond the coordinate range, zero slop
        settle();
        program_area(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
        apb_write(REG_SPARE, $urandom());
        send_sample(1, COORD_MAX, COORD_MAX);
        send_sample(1, COORD_MAX, COORD_MAX);
        send_sample(1, COORD_MAX - 1, COORD_MAX);
        send_sample(1, 0, 0);
        send_sample(0, 0, 0);
        send_sample(1, COORD_MAX - 1, COORD_MAX);

        // Single-point area, largest slop
        settle();
        program_area(0, 0, 0, 0, COORD_MAX);
        send_sample(1, 0, 0);
        send_sample(1, COORD_MAX, COORD_MAX);
        send_sample(0, 0, 0);
        send_sample(1, 1, 0);

        // Random phases, each with its own area and slop
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            if (phase == 0)
                program_area(0, 0, AREA_WIDTH_RESET, AREA_HEIGHT_RESET, TAP_SLOP_RESET);
            else if (phase == NUM_PHASES - 1)
                program_area(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, pick_slop());
            else if (phase == 2)
                program_area($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                             0, 0, pick_slop());
            else
                program_area($urandom_range(0, 2047), $urandom_range(0, 2047),
                             $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                             pick_slop());
            // one phase runs flat out on both sides
            tx_idling = (phase != 3);
            rx_idling = (phase != 3);
            if (phase == 1)
                hold_off_req = 1'b1;
            target = gesture_items + RANDOM_ITEMS / NUM_PHASES;
            while (gesture_items < target) begin
                if ($urandom_range(0, 99) < 15)
                    send_sample($urandom_range(0, 15), $urandom_range(0, COORD_MAX),
                                $urandom_range(0, COORD_MAX));
                else
                    run_gesture();
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
